>>> hdl/swa_pkg.sv
// Package for the sliding window aggregate: constants, mode codes, control structs.
// No dependencies.
`timescale 1ns / 1ps
package swa_pkg;
   localparam int WindowMaxDefault   = 64;
   localparam int SampleWidthDefault = 16;
   localparam int ResultWidth        = 32;
   localparam int LengthWidth        = 7;
   localparam int ModeWidth          = 3;
   localparam int CsrIndexWidth      = 1;

   localparam logic [ModeWidth-1:0] MODE_SUM   = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_MAX   = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_MIN   = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_COUNT = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_DEV   = 3'd4;

   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_LENGTH  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_AGGREGATE_MODE = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture item, write ring, clear accumulators
      logic walk;      // accumulate one window entry
      logic fin_start; // compute variance numerator
      logic sqrt_step; // one square root bit
      logic div_start; // load divider
      logic div_step;  // one quotient bit
      logic finish;    // form result
   } swa_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic walk_done;
      logic need_dev;
      logic sqrt_done;
      logic div_done;
   } swa_status_type;
endpackage

>>> hdl/swa_if.sv
// Valid/ready channel interfaces for the sliding window aggregate.
// No dependencies.
`timescale 1ns / 1ps
interface swa_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_value;
   logic                           sample_is_null;
   logic                           first_of_vector;
   modport source (output valid, sample_value, sample_is_null, first_of_vector, input ready);
   modport sink   (input valid, sample_value, sample_is_null, first_of_vector, output ready);
endinterface

interface swa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] window_result;
   logic               result_is_null;
   modport source (output valid, window_result, result_is_null, input ready);
   modport sink   (input valid, window_result, result_is_null, output ready);
endinterface

interface swa_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [6:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/sliding_window_aggregate_core.sv
// Top level of the sliding window aggregate: registers, controller, datapath.
// Depends on swa_pkg, swa_if, swa_ctrl, swa_datapath.
`timescale 1ns / 1ps
// One signed sample per item enters a ring of WINDOW_MAX entries; one result
// item leaves per input item: sum, max, min, non-null count, or population
// standard deviation (unsigned Q16.16) over the last window_length samples.
// Items are processed one at a time. An item is loaded, then the ring is
// walked over L entries through its single read port (L = effective window
// length), then the result is formed; deviation mode adds the square root
// (two radicand bits per cycle) and the restoring divider before the output
// (root width RW = 39 with the defaults). The result sits in an output
// register, so a stalled consumer holds only the next result. No clearing
// pass after reset.
module sliding_window_aggregate_core
   import swa_pkg::*;
#(
   parameter int WINDOW_MAX   = WindowMaxDefault,
   parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
   input  logic   clock,
   input  logic   reset,
   swa_req_if.sink   req,
   swa_rsp_if.source rsp,
   swa_csr_if.sink   csr
);
   logic [LengthWidth-1:0] window_length_ff;
   logic [ModeWidth-1:0]   aggregate_mode_ff;
   swa_cmd_type    cmd;
   swa_status_type status;
   logic rsp_load;
   logic [ResultWidth-1:0] res_value;
   logic res_null;
   logic rsp_valid_ff;
   logic [ResultWidth-1:0] rsp_value_ff;
   logic rsp_null_ff;

   // configuration: always ready, taken only while idle by contract
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff  <= LengthWidth'(1);
         aggregate_mode_ff <= MODE_SUM;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_WINDOW_LENGTH:  window_length_ff  <= csr.data;
            CSR_AGGREGATE_MODE: aggregate_mode_ff <= csr.data[ModeWidth-1:0];
            default: ;
         endcase
      end
   end

   swa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_free(!rsp_valid_ff || rsp.ready),
      .rsp_load(rsp_load), .cmd(cmd), .status(status)
   );

   swa_datapath #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .sample_value(req.sample_value), .sample_is_null(req.sample_is_null),
      .first_of_vector(req.first_of_vector),
      .window_length(window_length_ff), .aggregate_mode(aggregate_mode_ff),
      .result_value(res_value), .result_null(res_null)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= res_value;
         rsp_null_ff  <= res_null;
      end
   end
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.window_result  = rsp_value_ff;
   assign rsp.result_is_null = rsp_null_ff;
endmodule

>>> hdl/swa_ctrl.sv
// Sequencer for the sliding window aggregate: accepts an item, steps the datapath.
// Depends on swa_pkg.
`timescale 1ns / 1ps
module swa_ctrl
   import swa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           rsp_free,
   output logic           rsp_load,
   output swa_cmd_type    cmd,
   input  swa_status_type status
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WALK = 3'd1;
   localparam logic [2:0] ST_FIN  = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_DIVL = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_done) state_in = status.need_dev ? ST_FIN : ST_OUT;
            else cmd.walk = 1'b1;
         end
         ST_FIN: begin
            cmd.fin_start = 1'b1;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_done) state_in = ST_DIVL;
         end
         ST_DIVL: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               cmd.finish = 1'b1;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

>>> hdl/swa_datapath.sv
// Datapath: sample ring, window accumulators, bitwise square root and divider.
// Depends on swa_pkg.
`timescale 1ns / 1ps
module swa_datapath
   import swa_pkg::*;
#(
   parameter int WINDOW_MAX   = WindowMaxDefault,
   parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swa_cmd_type                    cmd,
   output swa_status_type                 status,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
   input  logic                           sample_is_null,
   input  logic                           first_of_vector,
   input  logic [LengthWidth-1:0]         window_length,
   input  logic [ModeWidth-1:0]           aggregate_mode,
   output logic [ResultWidth-1:0]         result_value,
   output logic                           result_null
);
   localparam int AW = $clog2(WINDOW_MAX);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int LW = (CW > LengthWidth) ? CW : LengthWidth;
   localparam int SW = SAMPLE_WIDTH + CW + 1;        // signed sum
   localparam int QW = 2 * SAMPLE_WIDTH + CW;        // sum of squares
   localparam int NW = QW + CW + 32;                 // scaled numerator
   localparam int RW = (NW + 1) / 2;                 // sqrt width
   localparam int SQW = 2 * RW;

   logic [SAMPLE_WIDTH:0] ring_mem [WINDOW_MAX];     // {null, value}
   logic [AW-1:0] slot_ff;
   logic [CW-1:0] hist_ff, len_ff, cnt_ff, idx_ff;
   logic [AW-1:0] rd_ff;
   logic          rd_valid_ff;
   logic [SAMPLE_WIDTH:0] rd_data_ff;
   logic signed [SW-1:0] sum_ff;
   logic [QW-1:0] sq_ff;
   logic signed [SAMPLE_WIDTH-1:0] best_ff;
   logic started_ff;
   logic [SQW-1:0] num_ff;
   logic [RW:0] srem_ff;
   logic [RW-1:0] root_ff;
   logic [$clog2(RW+1)-1:0] bit_ff;
   logic [RW-1:0] quo_ff, rem_ff;
   logic [$clog2(RW+1)-1:0] dbit_ff;

   // ring write and read
   logic [AW-1:0] wslot;
   logic [CW-1:0] hist_new, len_eff;
   logic [LW-1:0] wlen;
   always_comb begin
      wslot    = first_of_vector ? '0 : slot_ff;
      hist_new = first_of_vector ? CW'(1) :
                 ((hist_ff == CW'(WINDOW_MAX)) ? hist_ff : hist_ff + CW'(1));
      wlen     = LW'(window_length);
      len_eff  = (wlen > LW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(wlen);
      if (len_eff > hist_new) len_eff = hist_new;
   end

   always_ff @(posedge clock) begin
      if (cmd.load)
         ring_mem[wslot] <= {sample_is_null, sample_is_null ? '0 : sample_value};
      rd_data_ff <= ring_mem[rd_ff];
   end

   logic rd_go;
   assign rd_go = cmd.walk && (idx_ff < len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         hist_ff <= '0;
      end else if (cmd.load) begin
         slot_ff <= (wslot == AW'(WINDOW_MAX - 1)) ? '0 : wslot + AW'(1);
         hist_ff <= hist_new;
      end
   end

   // walk: address issued, data arrives next cycle
   logic signed [SAMPLE_WIDTH-1:0] v;
   logic [SAMPLE_WIDTH-1:0] mag;
   logic use_v;
   always_comb begin
      v     = signed'(rd_data_ff[SAMPLE_WIDTH-1:0]);
      mag   = v[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-v) : SAMPLE_WIDTH'(v);
      use_v = rd_valid_ff && !rd_data_ff[SAMPLE_WIDTH];
   end

   logic [2*SAMPLE_WIDTH-1:0] magsq;
   assign magsq = mag * mag;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff     <= len_eff;
         idx_ff     <= '0;
         rd_ff      <= wslot;
         rd_valid_ff <= 1'b0;
         sum_ff     <= '0;
         sq_ff      <= '0;
         cnt_ff     <= '0;
         started_ff <= 1'b0;
         best_ff    <= '0;
      end else begin
         rd_valid_ff <= rd_go;
         if (rd_go) begin
            idx_ff <= idx_ff + CW'(1);
            rd_ff  <= (rd_ff == '0) ? AW'(WINDOW_MAX - 1) : rd_ff - AW'(1);
         end
         if (use_v) begin
            sum_ff <= sum_ff + SW'(v);
            sq_ff  <= sq_ff + QW'(magsq);
            cnt_ff <= cnt_ff + CW'(1);
            started_ff <= 1'b1;
            if (!started_ff ||
                ((aggregate_mode == MODE_MAX) ? (v > best_ff) : (v < best_ff)))
               best_ff <= v;
         end
      end
   end

   logic walk_done_w;
   assign walk_done_w = (idx_ff == len_ff) && !rd_valid_ff;

   // deviation: num = (c*sq - s^2) << 32, root two radicand bits per step,
   // then root / c
   logic [SW-1:0] smag;
   logic [NW-1:0] cq, ss;
   logic [RW+2:0] sq_acc, sq_try;
   logic          sq_ge;
   always_comb begin
      smag   = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
      cq     = NW'(sq_ff) * NW'(cnt_ff);
      ss     = NW'(smag) * NW'(smag);
      sq_acc = {srem_ff, num_ff[SQW-1 -: 2]};
      sq_try = (RW+3)'({root_ff, 2'b01});
      sq_ge  = (sq_acc >= sq_try);
   end

   logic [RW:0] rtrial;
   assign rtrial = {rem_ff, quo_ff[RW-1]} - (RW+1)'(cnt_ff);

   always_ff @(posedge clock) begin
      if (cmd.fin_start) begin
         num_ff  <= SQW'(cq - ss) << 32;
         srem_ff <= '0;
         root_ff <= '0;
         bit_ff  <= $bits(bit_ff)'(RW - 1);
      end else if (cmd.sqrt_step) begin
         num_ff <= num_ff << 2;
         if (sq_ge) begin
            srem_ff <= sq_acc[RW:0] - sq_try[RW:0];
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            srem_ff <= sq_acc[RW:0];
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
         bit_ff <= bit_ff - 1'b1;
      end
      if (cmd.div_start) begin
         quo_ff  <= root_ff;
         rem_ff  <= '0;
         dbit_ff <= $bits(dbit_ff)'(RW);
      end else if (cmd.div_step) begin
         if (!rtrial[RW]) rem_ff <= rtrial[RW-1:0];
         else rem_ff <= {rem_ff[RW-2:0], quo_ff[RW-1]};
         quo_ff  <= {quo_ff[RW-2:0], !rtrial[RW]};
         dbit_ff <= dbit_ff - 1'b1;
      end
   end

   always_comb begin
      status.walk_done = walk_done_w;
      status.need_dev  = (aggregate_mode == MODE_DEV) && (cnt_ff != '0);
      status.sqrt_done = (bit_ff == '0);
      status.div_done  = (dbit_ff == $bits(dbit_ff)'(1));
   end

   // final result
   logic signed [63:0] sum_wide;
   assign sum_wide = 64'(sum_ff);

   always_comb begin
      result_value = '0;
      result_null  = 1'b0;
      unique case (aggregate_mode)
         MODE_SUM: begin
            if (sum_wide > 64'sh7fffffff) result_value = 32'h7fffffff;
            else if (sum_wide < -64'sh80000000) result_value = 32'h80000000;
            else result_value = sum_wide[31:0];
         end
         MODE_MAX, MODE_MIN: begin
            if (started_ff) result_value = 32'(best_ff);
            else result_null = 1'b1;
         end
         MODE_COUNT: result_value = 32'(cnt_ff);
         MODE_DEV: begin
            if (cnt_ff == '0) result_null = 1'b1;
            else if (|(quo_ff >> 32)) result_value = 32'hffffffff;
            else result_value = 32'(quo_ff);
         end
         default: ;
      endcase
   end
endmodule

>>> hdl/swa_checker.sv
// Port-level checker for the sliding window aggregate, bound to the top level.
// No dependencies.
`timescale 1ns / 1ps
module swa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_window_result,
   input logic        rsp_result_is_null
);
   // one item in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("back-to-back accept");
   // a null result always carries zero
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_is_null) |-> (rsp_window_result == 32'd0))
      else $error("null result not zero");
   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_window_result)))
      else $error("result changed under stall");
endmodule

bind sliding_window_aggregate_core swa_checker u_swa_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_window_result(rsp.window_result), .rsp_result_is_null(rsp.result_is_null)
);
